// ===== rtl/srs_pkg.sv =====
package srs_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_DISABLE = 2'd2,
      OP_CULL    = 2'd3
   } op_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
   } rect_type;

   typedef struct packed {
      logic     valid;
      logic     screen;
      rect_type rect;
   } entry_type;

   typedef struct packed {
      rect_type rect;
      logic     outside;
   } alu_out_type;

   // Clamp a 17-bit signed sum to the 16-bit signed range.
   function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
      logic signed [15:0] r;
      if (v[16] != v[15]) begin
         r = v[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/scissor_rect_stack.sv =====
// Scissor rectangle stack.
// Request channel (req_*): one beat carries an opcode (push, pop, disable
// marker, cull test), a rectangle or query box and the push flags. The block
// drives req_stall; a beat is taken when req_valid is high and req_stall low.
// Response channel (rsp_*): exactly one beat per request, in request order,
// with the applied scissor, the cull result and the empty and error flags.
// Each request passes ST_IDLE then ST_EXEC: the accept reads the stack entry it
// needs from the single-port entry memory into rd_ff; ST_EXEC computes the
// result, writes any pushed entry back and loads the response register.
// The block takes no new request until the previous one has left ST_EXEC;
// the memory read of the top (or, for pop, the entry below it) is registered at accept.
// A new request is accepted while a response still waits in its register;
// while rsp_stall holds the response, the following request waits in its
// compute cycle and no further request is accepted.
// Reset (synchronous, active high) empties the stack and drops any pending
// response. Entry memory contents are not cleared; only entries below the
// stack count affect a response.
module scissor_rect_stack
   import srs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_rect_x,
   input  logic signed [15:0] req_rect_y,
   input  logic signed [15:0] req_rect_w,
   input  logic signed [15:0] req_rect_h,
   input  logic               req_to_screen,
   input  logic               req_skip_clip,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_scissor_on,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_w,
   output logic signed [15:0] rsp_out_h,
   output logic               rsp_out_screen,
   output logic               rsp_rect_applied,
   output logic               rsp_outside,
   output logic               rsp_is_empty,
   output logic               rsp_error
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // latched request
   op_type   op_ff;
   rect_type req_rect_ff;
   logic     screen_ff, skip_ff;

   // entry memory
   entry_type        mem [STACK_DEPTH];
   entry_type        rd_ff;
   logic [CNT_W-1:0] rd_ptr;
   logic             mem_we;
   entry_type        mem_wdata;

   // response register
   logic     on_ff, on_in, scr_ff, scr_in, app_ff, app_in;
   logic     out_ff, out_in, empty_ff, empty_in, err_ff, err_in;
   rect_type rect_ff, rect_in;

   logic        accept, exec_go, top_present, top_valid, full, below_valid;
   alu_out_type alu_res;

   assign accept  = req_valid && !req_stall;
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // pop looks at the entry below the top, everything else at the top
   assign rd_ptr = (op_type'(req_opcode) == OP_POP) ? count_ff - CNT_W'(2)
                                                   : count_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= mem_wdata;
      end
      if (accept) begin
         rd_ff <= mem[rd_ptr[ADDR_W-1:0]];
      end
   end

   assign top_present = (count_ff != '0);
   assign top_valid   = top_present && rd_ff.valid;
   assign full        = (count_ff == CNT_W'(STACK_DEPTH));
   assign below_valid = (count_ff > CNT_W'(1)) && rd_ff.valid;

   srs_alu u_alu (
      .req_rect    (req_rect_ff),
      .top_rect    (rd_ff.rect),
      .do_clip     (!skip_ff && top_valid),
      .top_present (top_present),
      .top_valid   (top_valid),
      .result      (alu_res)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      mem_we    = 1'b0;
      mem_wdata = '0;
      rect_in   = '0;
      scr_in    = 1'b0;
      app_in    = 1'b0;
      out_in    = 1'b0;
      err_in    = 1'b0;
      empty_in  = !top_valid;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      case (op_ff)
         OP_PUSH: begin
            if (full) begin
               err_in = 1'b1;
            end else begin
               mem_we    = exec_go;
               mem_wdata = '{valid: 1'b1, screen: screen_ff, rect: alu_res.rect};
               count_in  = exec_go ? count_ff + CNT_W'(1) : count_ff;
               rect_in   = alu_res.rect;
               scr_in    = screen_ff;
               app_in    = 1'b1;
               empty_in  = 1'b0;
            end
         end
         OP_DISABLE: begin
            if (full) begin
               err_in = 1'b1;
            end else begin
               // invalid marker: all-zero entry
               mem_we   = exec_go;
               count_in = exec_go ? count_ff + CNT_W'(1) : count_ff;
               empty_in = 1'b1;
            end
         end
         OP_POP: begin
            if (!top_present) begin
               err_in   = 1'b1;
               empty_in = 1'b1;
            end else begin
               count_in = exec_go ? count_ff - CNT_W'(1) : count_ff;
               empty_in = !below_valid;
               if (below_valid) begin
                  rect_in = rd_ff.rect;
                  scr_in  = rd_ff.screen;
                  app_in  = 1'b1;
               end
            end
         end
         OP_CULL: begin
            out_in = alu_res.outside;
         end
         default: ;
      endcase

      on_in = !empty_in;

      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request beat for the compute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op_type'(req_opcode);
         req_rect_ff <= '{x: req_rect_x, y: req_rect_y, w: req_rect_w, h: req_rect_h};
         screen_ff   <= req_to_screen;
         skip_ff     <= req_skip_clip;
      end
   end

   // load the response only when the previous one has left
   always_ff @(posedge clock) begin
      if (exec_go) begin
         on_ff    <= on_in;
         rect_ff  <= rect_in;
         scr_ff   <= scr_in;
         app_ff   <= app_in;
         out_ff   <= out_in;
         empty_ff <= empty_in;
         err_ff   <= err_in;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scissor_on   = on_ff;
   assign rsp_out_x        = rect_ff.x;
   assign rsp_out_y        = rect_ff.y;
   assign rsp_out_w        = rect_ff.w;
   assign rsp_out_h        = rect_ff.h;
   assign rsp_out_screen   = scr_ff;
   assign rsp_rect_applied = app_ff;
   assign rsp_outside      = out_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_error        = err_ff;

endmodule

// ===== rtl/srs_alu.sv =====
module srs_alu
   import srs_pkg::*;
(
   input  rect_type    req_rect,
   input  rect_type    top_rect,
   input  logic        do_clip,
   input  logic        top_present,
   input  logic        top_valid,
   output alu_out_type result
);

   logic signed [15:0] nx, ny, bx, by, ex, ey, lx, ly;
   logic               overlap;

   always_comb begin
      // clip: larger low edge, smaller high edge, size from the difference
      nx = (top_rect.x > req_rect.x) ? top_rect.x : req_rect.x;
      ny = (top_rect.y > req_rect.y) ? top_rect.y : req_rect.y;
      bx = sat16({top_rect.x[15], top_rect.x} + {top_rect.w[15], top_rect.w});
      by = sat16({top_rect.y[15], top_rect.y} + {top_rect.h[15], top_rect.h});
      ex = sat16({req_rect.x[15], req_rect.x} + {req_rect.w[15], req_rect.w});
      ey = sat16({req_rect.y[15], req_rect.y} + {req_rect.h[15], req_rect.h});
      lx = (bx > ex) ? ex : bx;
      ly = (by > ey) ? ey : by;

      if (do_clip) begin
         result.rect.x = nx;
         result.rect.y = ny;
         result.rect.w = sat16({lx[15], lx} - {nx[15], nx});
         result.rect.h = sat16({ly[15], ly} - {ny[15], ny});
      end else begin
         result.rect = req_rect;
      end

      // cull: query is min x/y in x,y and max x/y in w,h; touching is outside
      overlap = (req_rect.x < bx) && (req_rect.w > top_rect.x) &&
                (req_rect.y < by) && (req_rect.h > top_rect.y);
      if (!top_present) begin
         result.outside = 1'b0;
      end else if (!top_valid) begin
         result.outside = 1'b1;
      end else begin
         result.outside = !overlap;
      end
   end

endmodule

// ===== verif/scissor_rect_stack_checker.sv =====
`timescale 1ns / 100ps
module scissor_rect_stack_checker
   import srs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_rect_x,
   input  logic signed [15:0] req_rect_y,
   input  logic signed [15:0] req_rect_w,
   input  logic signed [15:0] req_rect_h,
   input  logic               req_to_screen,
   input  logic               req_skip_clip,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_scissor_on,
   input  logic signed [15:0] rsp_out_x,
   input  logic signed [15:0] rsp_out_y,
   input  logic signed [15:0] rsp_out_w,
   input  logic signed [15:0] rsp_out_h,
   input  logic               rsp_out_screen,
   input  logic               rsp_rect_applied,
   input  logic               rsp_outside,
   input  logic               rsp_is_empty,
   input  logic               rsp_error,
   output int                 fail_count,
   output int                 outstanding
);

   typedef struct {
      logic               on;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
      logic               screen;
      logic               applied;
      logic               outside;
      logic               empty;
      logic               err;
   } scissor_result_type;

   // shadow copy of the rectangle stack
   rect_type           entry_rect   [STACK_DEPTH];
   logic               entry_valid  [STACK_DEPTH];
   logic               entry_screen [STACK_DEPTH];
   int                 depth;
   scissor_result_type expected_q [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
      depth       = 0;
   end

   function automatic int clamp_s16(int v);
      int r;
      r = v;
      if (v > 32767) r = 32767;
      if (v < -32768) r = -32768;
      return r;
   endfunction

   function automatic logic top_is_off();
      return depth == 0 || !entry_valid[depth - 1];
   endfunction

   function automatic scissor_result_type predict_scissor(op_type op, int x, int y, int w,
                                                         int h, logic scr, logic skip);
      scissor_result_type r;
      int tx, ty, tw, th, nx, ny, bx, by, ex, ey, mx, my;
      r = '{default: '0};
      if (depth > 0) begin
         tx = entry_rect[depth - 1].x;
         ty = entry_rect[depth - 1].y;
         tw = entry_rect[depth - 1].w;
         th = entry_rect[depth - 1].h;
      end
      case (op)
         OP_PUSH, OP_DISABLE: begin
            if (depth >= STACK_DEPTH) begin
               r.err = 1'b1;
            end else if (op == OP_DISABLE) begin
               entry_rect[depth]   = '0;
               entry_valid[depth]  = 1'b0;
               entry_screen[depth] = 1'b0;
               depth++;
            end else begin
               // clip against the top unless told not to or nothing valid to clip to
               if (!skip && !top_is_off()) begin
                  nx = (tx > x) ? tx : x;
                  ny = (ty > y) ? ty : y;
                  bx = clamp_s16(tx + tw);
                  by = clamp_s16(ty + th);
                  ex = clamp_s16(x + w);
                  ey = clamp_s16(y + h);
                  w  = clamp_s16(((bx > ex) ? ex : bx) - nx);
                  h  = clamp_s16(((by > ey) ? ey : by) - ny);
                  x  = nx;
                  y  = ny;
               end
               entry_rect[depth]   = '{x: x[15:0], y: y[15:0], w: w[15:0], h: h[15:0]};
               entry_valid[depth]  = 1'b1;
               entry_screen[depth] = scr;
               depth++;
               r.applied = 1'b1;
               r.screen  = scr;
               r.x = x[15:0];
               r.y = y[15:0];
               r.w = w[15:0];
               r.h = h[15:0];
            end
         end
         OP_POP: begin
            if (depth == 0) begin
               r.err = 1'b1;
            end else begin
               depth--;
               if (!top_is_off()) begin
                  r.x       = entry_rect[depth - 1].x;
                  r.y       = entry_rect[depth - 1].y;
                  r.w       = entry_rect[depth - 1].w;
                  r.h       = entry_rect[depth - 1].h;
                  r.screen  = entry_screen[depth - 1];
                  r.applied = 1'b1;
               end
            end
         end
         default: begin
            if (depth == 0) begin
               r.outside = 1'b0;
            end else if (top_is_off()) begin
               r.outside = 1'b1;
            end else begin
               mx = clamp_s16(tx + tw);
               my = clamp_s16(ty + th);
               r.outside = !(x < mx && w > tx && y < my && h > ty);
            end
         end
      endcase
      r.empty = top_is_off();
      r.on    = !r.empty;
      return r;
   endfunction

   function automatic void compare_field(string name, logic signed [31:0] want,
                                         logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      scissor_result_type want;
      if (reset) begin
         depth = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("rsp beat with no request waiting");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               compare_field("rsp_scissor_on", want.on, rsp_scissor_on);
               compare_field("rsp_out_x", want.x, rsp_out_x);
               compare_field("rsp_out_y", want.y, rsp_out_y);
               compare_field("rsp_out_w", want.w, rsp_out_w);
               compare_field("rsp_out_h", want.h, rsp_out_h);
               compare_field("rsp_out_screen", want.screen, rsp_out_screen);
               compare_field("rsp_rect_applied", want.applied, rsp_rect_applied);
               compare_field("rsp_outside", want.outside, rsp_outside);
               compare_field("rsp_is_empty", want.empty, rsp_is_empty);
               compare_field("rsp_error", want.err, rsp_error);
            end
         end
         if (req_valid && !req_stall) begin
            expected_q.insert(expected_q.size(),
                              predict_scissor(op_type'(req_opcode), req_rect_x, req_rect_y,
                                              req_rect_w, req_rect_h, req_to_screen,
                                              req_skip_clip));
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

// ===== verif/scissor_rect_stack_tb.sv =====
`timescale 1ns / 100ps
module scissor_rect_stack_tb;
   import srs_pkg::*;

   // the limit leaves plenty of room for the slowest beats
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BEATS = 1220;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode       = OP_PUSH;
   logic signed [15:0] req_rect_x       = '0;
   logic signed [15:0] req_rect_y       = '0;
   logic signed [15:0] req_rect_w       = '0;
   logic signed [15:0] req_rect_h       = '0;
   logic               req_to_screen    = 1'b0;
   logic               req_skip_clip    = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic               rsp_scissor_on;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic signed [15:0] rsp_out_w;
   logic signed [15:0] rsp_out_h;
   logic               rsp_out_screen;
   logic               rsp_rect_applied;
   logic               rsp_outside;
   logic               rsp_is_empty;
   logic               rsp_error;

   int fail_count;
   int outstanding;
   int cycle_count = 0;

   // when set, the matching side runs back to back with no idle cycles
   bit send_quiet  = 1'b0;
   bit stall_quiet = 1'b0;

   always #6 clock = ~clock;

   scissor_rect_stack u_top (.*);

   scissor_rect_stack_checker u_check (.*);

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("scissor_rect_stack_tb failed");
         $finish;
      end
   end

   // Response side: draw a stall length per beat, hold it, then release and
   // wait for the next beat to go through. Now and then run a stretch with
   // no stalls at all.
   initial begin
      int hold;
      int served;
      served = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (served % 30 == 0) stall_quiet = ($urandom_range(0, 4) == 0);
         hold = stall_quiet ? 0 : $urandom_range(0, 17);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         served++;
      end
   end

   // Send one request beat. Drop valid only when an idle gap is drawn, so a
   // back-to-back beat keeps valid high across the handshake edge. Return at
   // the edge that took the beat, with nothing yet scheduled for that step.
   task automatic send_item(op_type op, int x, int y, int w, int h, bit scr, bit skip);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_rect_x    <= x[15:0];
      req_rect_y    <= y[15:0];
      req_rect_w    <= w[15:0];
      req_rect_h    <= h[15:0];
      req_to_screen <= scr;
      req_skip_clip <= skip;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off new requests until every outstanding response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Coordinates: mostly a small window so clipped rectangles overlap,
   // with full-range values and the saturation corners mixed in.
   function automatic int pick_coord();
      int r;
      case ($urandom_range(0, 7))
         0:       r = $urandom_range(0, 1) ? 32767 : -32768;
         1, 2:    r = int'($urandom_range(0, 65535)) - 32768;
         default: r = int'($urandom_range(0, 600)) - 200;
      endcase
      return r;
   endfunction

   // mix 0 grows the stack into overflow, mix 1 drains it into underflow,
   // mix 2 keeps it wandering in between.
   task automatic random_item(int mix);
      int     pick;
      op_type op;
      pick = $urandom_range(0, 99);
      case (mix)
         0:       op = pick < 60 ? OP_PUSH : pick < 72 ? OP_DISABLE :
                       pick < 88 ? OP_CULL : OP_POP;
         1:       op = pick < 20 ? OP_PUSH : pick < 28 ? OP_DISABLE :
                       pick < 45 ? OP_CULL : OP_POP;
         default: op = pick < 35 ? OP_PUSH : pick < 45 ? OP_DISABLE :
                       pick < 70 ? OP_CULL : OP_POP;
      endcase
      send_item(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0));
   endtask

   initial begin
      int mix;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // pop and cull on an empty stack
      send_item(OP_POP, 0, 0, 0, 0, 1'b0, 1'b0);
      send_item(OP_CULL, -5, -5, 5, 5, 1'b0, 1'b0);
      // widest rectangle; nothing below it to clip against
      send_item(OP_PUSH, -32768, -32768, 32767, 32767, 1'b1, 1'b0);
      // clip at the far corner: the request's edge sums saturate
      send_item(OP_PUSH, 32767, 32767, 32767, 32767, 1'b0, 1'b0);
      send_item(OP_POP, 0, 0, 0, 0, 1'b0, 1'b0);
      // negative size stored unclipped
      send_item(OP_PUSH, 100, 200, -32768, 50, 1'b1, 1'b1);
      send_item(OP_CULL, 0, 0, 100, 250, 1'b0, 1'b0);
      send_item(OP_POP, 0, 0, 0, 0, 1'b0, 1'b0);
      // query that only touches the right edge, then one well inside
      send_item(OP_CULL, -1, -100, 50, 50, 1'b0, 1'b0);
      send_item(OP_CULL, -100, -100, -50, -50, 1'b0, 1'b0);
      // disable marker: cull reports outside, push on it skips the clip
      send_item(OP_DISABLE, 0, 0, 0, 0, 1'b0, 1'b0);
      send_item(OP_CULL, -100, -100, -50, -50, 1'b0, 1'b0);
      send_item(OP_PUSH, 10, 10, 20, 20, 1'b0, 1'b0);
      // pop onto the marker turns scissoring off, the next pop restores it
      send_item(OP_POP, 0, 0, 0, 0, 1'b0, 1'b0);
      send_item(OP_POP, 0, 0, 0, 0, 1'b0, 1'b0);
      // fill to the top with nested rectangles, then overflow both ways
      for (int i = 1; i < STACK_DEPTH; i++) begin
         send_item(OP_PUSH, i * 100 - 1000, i * 50, 2000, 1500 - i * 90, 1'(i), i == 7);
      end
      send_item(OP_PUSH, 0, 0, 10, 10, 1'b1, 1'b0);
      send_item(OP_DISABLE, 0, 0, 0, 0, 1'b0, 1'b0);
      send_item(OP_CULL, -200, 0, 800, 900, 1'b0, 1'b0);
      wait_idle();

      // random traffic in blocks, each with its own op mix and idle style
      mix = 2;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0) begin
            mix        = $urandom_range(0, 2);
            send_quiet = ($urandom_range(0, 3) == 0);
         end
         if (n > 0 && n % 300 == 0) wait_idle();
         random_item(mix);
      end

      // drain, then give the block time to emit anything stray
      wait_idle();
      repeat (16) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("scissor_rect_stack_tb passed");
      end else begin
         $display("scissor_rect_stack_tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/srs_pkg.sv
rtl/srs_alu.sv
rtl/scissor_rect_stack.sv
verif/scissor_rect_stack_checker.sv
verif/scissor_rect_stack_tb.sv
